// ===== sv/sha256_pkg.sv =====
// Package with SHA-256 constants, types and round functions.
package sha256_pkg;

  localparam int unsigned WordW = 32;

  typedef logic [WordW-1:0] word_t;

  // One queued beat between the front and back parts.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } item_t;

  localparam word_t InitHash [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam word_t RoundConst [64] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  // Byte position at which the length field starts in the final block.
  localparam logic [5:0] LenPos = 6'd56;

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StPad   = 5'b00010,
    StRound = 5'b00100,
    StFold  = 5'b01000,
    StOut   = 5'b10000
  } core_state_e;

  function automatic word_t rotr(word_t x, int unsigned n);
    rotr = (x >> n) | (x << (WordW - n));
  endfunction

  function automatic word_t big_s0(word_t x);
    big_s0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_s1(word_t x);
    big_s1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t small_s0(word_t x);
    small_s0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_s1(word_t x);
    small_s1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

// ===== sv/sha256_fifo.sv =====
// Two-entry queue that carries input beats from the front part to the core.
module sha256_fifo
  import sha256_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t push_data_i,
  output logic  full_o,
  input  logic  pop_i,
  output item_t pop_data_o,
  output logic  empty_o
);

  item_t      mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o     = (count_q == 2'd2);
  assign empty_o    = (count_q == 2'd0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i && !full_o) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i && !empty_o) rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + 2'((push_i && !full_o) ? 1 : 0)
                         - 2'((pop_i && !empty_o) ? 1 : 0);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3) else $error("queue count out of range");
  a_empty_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o && !push_i |=> empty_o) else $error("queue filled without push");
  a_full_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o && !pop_i |=> full_o) else $error("queue drained without pop");

endmodule

// ===== sv/sha256_core.sv =====
// SHA-256 back part: block packing, padding, 64 rounds and digest output.
module sha256_core
  import sha256_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        item_valid_i,
  input  item_t       item_i,
  output logic        item_pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  core_state_e state_q, state_d;
  word_t       hash_q [8];
  word_t       wv_q [8];
  word_t       win_q [16];
  logic [5:0]  bcnt_q;
  logic [63:0] bitlen_q;
  logic [5:0]  round_q;
  logic        final_q;  // current compression belongs to padding
  logic [2:0]  oidx_q;

  // Pending padding after a block compressed by the last data byte.
  logic pend_q;
  // Set once the zero fill has reached the length field of the final block.
  logic len_q;
  // Set when the compression in flight holds the length field.
  logic pad_done_q;

  // Byte fed by the padding sequencer.
  logic [7:0]  pad_byte;
  logic [7:0]  wr_byte;
  logic        wr_en;
  logic [5:0]  pad_sel;
  word_t       w_new, w_cur, t1, t2;

  assign pad_sel = bcnt_q - LenPos;
  always_comb begin
    if (final_q) begin
      // final_q here marks that the 0x80 byte went in already.
      if (len_q) begin
        pad_byte = bitlen_q[8'd63 - {pad_sel[2:0], 3'b000} -: 8];
      end else begin
        pad_byte = 8'h00;
      end
    end else begin
      pad_byte = 8'h80;
    end
  end

  assign item_pop_o = (state_q == StIdle) && item_valid_i;
  assign wr_en   = item_pop_o ? item_i.has_byte : (state_q == StPad);
  assign wr_byte = item_pop_o ? item_i.data_byte : pad_byte;

  assign w_new = small_s1(win_q[4'(round_q - 6'd2)]) + win_q[4'(round_q - 6'd7)]
               + small_s0(win_q[4'(round_q - 6'd15)]) + win_q[round_q[3:0]];
  assign w_cur = (round_q >= 6'd16) ? w_new : win_q[round_q[3:0]];
  assign t1 = wv_q[7] + big_s1(wv_q[4])
            + ((wv_q[4] & wv_q[5]) ^ (~wv_q[4] & wv_q[6]))
            + RoundConst[round_q] + w_cur;
  assign t2 = big_s0(wv_q[0])
            + ((wv_q[0] & wv_q[1]) ^ (wv_q[0] & wv_q[2]) ^ (wv_q[1] & wv_q[2]));

  logic pad_done;  // length field ends the final block
  assign pad_done = len_q && (bcnt_q == 6'd63);

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (item_pop_o) begin
          if (item_i.has_byte && bcnt_q == 6'd63) state_d = StRound;
          else if (item_i.end_of_message)         state_d = StPad;
        end
      end
      StPad:   if (bcnt_q == 6'd63) state_d = StRound;
      StRound: if (round_q == 6'd63) state_d = StFold;
      StFold: begin
        if (pad_done_q)             state_d = StOut;
        else if (final_q || pend_q) state_d = StPad;
        else                        state_d = StIdle;
      end
      StOut:   if (!out_stall_i && oidx_q == 3'd7) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      hash_q   <= InitHash;
      bcnt_q   <= 6'd0;
      bitlen_q <= 64'd0;
      round_q  <= 6'd0;
      final_q  <= 1'b0;
      pend_q   <= 1'b0;
      len_q    <= 1'b0;
      oidx_q   <= 3'd0;
    end else begin
      state_q <= state_d;
      if (wr_en) bcnt_q <= bcnt_q + 6'd1;
      if (item_pop_o && item_i.has_byte) bitlen_q <= bitlen_q + 64'd8;
      if (item_pop_o) pend_q <= item_i.end_of_message && item_i.has_byte
                                && bcnt_q == 6'd63;
      if (state_q == StPad) final_q <= 1'b1;
      if (state_q == StPad && bcnt_q == LenPos - 6'd1) len_q <= 1'b1;
      if (state_q == StRound) round_q <= round_q + 6'd1;
      if (state_q == StFold) begin
        for (int i = 0; i < 8; i++) hash_q[i] <= hash_q[i] + wv_q[i];
        pend_q <= 1'b0;
      end
      if (state_q == StOut && !out_stall_i) begin
        oidx_q <= oidx_q + 3'd1;
        if (oidx_q == 3'd7) begin
          hash_q   <= InitHash;
          bitlen_q <= 64'd0;
          final_q  <= 1'b0;
          len_q    <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pad_done_q <= 1'b0;
    end else if (state_q == StPad && pad_done) begin
      pad_done_q <= 1'b1;
    end else if (state_q == StOut) begin
      pad_done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      if (bcnt_q[1:0] == 2'd0) begin
        win_q[bcnt_q[5:2]] <= {wr_byte, 24'd0};
      end else begin
        win_q[bcnt_q[5:2]][8'(8'd31 - {bcnt_q[1:0], 3'b000}) -: 8] <= wr_byte;
      end
    end
    if (state_q == StRound) begin
      win_q[round_q[3:0]] <= w_cur;
      wv_q[7] <= wv_q[6];
      wv_q[6] <= wv_q[5];
      wv_q[5] <= wv_q[4];
      wv_q[4] <= wv_q[3] + t1;
      wv_q[3] <= wv_q[2];
      wv_q[2] <= wv_q[1];
      wv_q[1] <= wv_q[0];
      wv_q[0] <= t1 + t2;
    end else begin
      wv_q <= hash_q;
    end
  end

  assign out_valid_o   = (state_q == StOut);
  assign digest_word_o = hash_q[oidx_q];
  assign word_index_o  = oidx_q;
  assign last_word_o   = (oidx_q == 3'd7);

  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("core state not one-hot");
  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_pop_o |-> state_q == StIdle) else $error("beat taken while busy");
  a_round_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StFold |-> round_q == 6'd0) else $error("round count off");

endmodule

// ===== sv/sha256_hash_engine.sv =====
// Top level of the SHA-256 hash engine: input queue and compression core.
// A byte that fills a block starts a compression of 64 rounds and a fold;
// an end-of-message beat adds padding, one or two compressions, then eight
// digest beats, one per cycle when taken. The core takes one byte per cycle
// between blocks and none while it pads, compresses or outputs, since it has
// a single round unit. Reset restores the initial hash.
module sha256_hash_engine
  import sha256_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        has_byte_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  // The front part queues beats so the sender can keep going while a block
  // compresses; idle beats that carry neither a byte nor an end mark are
  // dropped here since they change nothing.
  item_t in_item, q_item;
  logic  q_full, q_empty, q_pop, push;

  assign in_item = '{data_byte: data_byte_i, has_byte: has_byte_i,
                     end_of_message: end_of_message_i};
  assign in_stall_o = q_full;
  assign push = in_valid_i && (has_byte_i || end_of_message_i);

  sha256_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(in_item),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .pop_data_o (q_item),
    .empty_o    (q_empty)
  );

  sha256_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (!q_empty),
    .item_i       (q_item),
    .item_pop_o   (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .digest_word_o(digest_word_o),
    .word_index_o (word_index_o),
    .last_word_o  (last_word_o)
  );

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(word_index_o))
    else $error("output beat dropped under stall");
  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> last_word_o == (word_index_o == 3'd7))
    else $error("last word flag mismatch");
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> !q_empty) else $error("stall with empty queue");

endmodule
